// ===== hw/rtl/g2p_pkg.sv =====
// Shared types, constants and calendar tables for the Gregorian to Persian date unit.
// Used by g2p_flow and gregorian_to_persian_date_unit; depends on nothing else.
package g2p_pkg;

    // Number of register stages from the input register to the result register.
    localparam int STAGES = 13;

    // Stage handshake control handed from the flow controller to the datapath.
    typedef struct packed {
        logic [STAGES-1:0] en;   // stage loads at the next edge
        logic [STAGES-1:0] vld;  // stage holds a live beat
    } t_flow;

    // Reciprocal multipliers for division by constants (multiply, then shift right).
    localparam int REC100    = 10486;    // exact for dividends below 43690
    localparam int REC100_SH = 20;
    localparam int REC366    = 1466861;  // exact for dividends below 2^21
    localparam int REC366_SH = 29;
    localparam int REC11     = 11916;    // exact for dividends below 32768
    localparam int REC11_SH  = 17;

    // Day-number constants.
    localparam int CYCLE_DAYS  = 1029983;  // days in one 2820-year cycle
    localparam int CYCLE_YEARS = 2820;
    localparam int EPOCH_YEAR  = 474;
    localparam int YEAR_SPAN   = 1028522;  // divisor of the year-in-cycle formula
    // Day number minus the Persian epoch plus one cycle, so the value stays positive:
    // 1721059 (Gregorian base less one year) - 2121445 (epoch) + 1029983.
    localparam int DSH_BIAS    = 629597;
    // Year-start offset in the day-of-year formula: 2121445 - 1948319 - 473 * 365.
    localparam int YDAY_BIAS   = 481;
    // First Persian year of cycle index zero is 474 - 2820.
    localparam int YEAR_BIAS   = 2346;

    // floor((367 * m - 362) / 12) for every 4-bit month code, month zero included.
    localparam int GREG_MON_OFF [16] = '{
        -31,   0,  31,  61,  92, 122, 153, 183,
        214, 245, 275, 306, 336, 367, 398, 428
    };

    // Day of the Persian year on which month (idx + 1) begins.
    function automatic logic [8:0] pers_month_first(input logic [3:0] idx);
        logic [8:0] first;
        case (idx)
            4'd0:    first = 9'd1;
            4'd1:    first = 9'd32;
            4'd2:    first = 9'd63;
            4'd3:    first = 9'd94;
            4'd4:    first = 9'd125;
            4'd5:    first = 9'd156;
            4'd6:    first = 9'd187;
            4'd7:    first = 9'd217;
            4'd8:    first = 9'd247;
            4'd9:    first = 9'd277;
            4'd10:   first = 9'd307;
            4'd11:   first = 9'd337;
            default: first = 9'd1;
        endcase
        return first;
    endfunction

endpackage

// ===== hw/rtl/g2p_flow.sv =====
// Valid and load-enable chain for the date conversion pipeline.
// Depends on g2p_pkg for the stage count and the t_flow control struct.
module g2p_flow (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_ready,
    output g2p_pkg::t_flow o_flow
);
    import g2p_pkg::*;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    logic [STAGES-1:0] w_en;
    logic              w_in_acc;
    logic              w_out_acc;

    // A stage loads when it is empty or when the stage after it moves on, so
    // bubbles close up and the input keeps flowing in an output stall until full.
    always_comb begin
        w_en[STAGES-1] = !r_vld[STAGES-1] || i_out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
        n_vld = r_vld;
        if (w_en[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (w_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_flow.en  = w_en;
    assign o_flow.vld = r_vld;

    assign w_in_acc  = i_in_valid && w_en[0];
    assign w_out_acc = r_vld[STAGES-1] && i_out_ready;

    // Beats in flight change only by what enters and what leaves.
    a_conserve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ($countones(r_vld) == $past($countones(r_vld))
                  + 32'($past(w_in_acc)) - 32'($past(w_out_acc))))
        else $error("g2p_flow: beat count in the pipeline is not conserved");

    // A full pipeline with a stalled output cannot take another beat.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld && !i_out_ready) |-> !w_en[0])
        else $error("g2p_flow: input accepted while the pipeline is full and stalled");

    // Reset empties every stage.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("g2p_flow: pipeline not empty after reset");

endmodule

// ===== hw/rtl/gregorian_to_persian_date_unit.sv =====
// Gregorian to Persian (Solar Hijri) date converter, top level with the datapath.
// Depends on g2p_pkg for constants and tables and on g2p_flow for stage control.
//
// One Gregorian date per beat goes in and one Persian date per beat comes out, in order.
// The unit is a 13-stage pipeline, and a new date can be taken every cycle while the
// output is not stalled, so the sustained rate is one beat per cycle.
// Each stage holds a short step of constant-operand multiplies, wide adds or a compare
// set, which is what sets the depth. Stages close up around bubbles, so the input
// stays ready while a finished result waits, until all 13 stages hold a beat.
// Dates are not checked: a day of zero, a day past the end of its month, month codes
// 0 and 13 to 15 and year zero follow the same formulas and give the date that many
// days away. Persian years at or before the epoch skip year zero and are output in
// two's complement. The unit keeps no state between dates.
module gregorian_to_persian_date_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input beat, bits from the lowest up: greg_day[4:0], greg_month[8:5],
    // greg_year[22:9], bit 23 unused and zero.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    // Result beat, bits from the lowest up: pers_day[4:0], pers_month[8:5],
    // pers_year[23:9] (two's complement).
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata
);
    import g2p_pkg::*;

    t_flow flow;

    // Stage registers, numbered by the stage that holds them.
    logic [4:0]  r_s0_day;
    logic [3:0]  r_s0_mon;
    logic [13:0] r_s0_yr;

    logic [4:0]  r_s1_day;
    logic [3:0]  r_s1_mon;
    logic [13:0] r_s1_yr;
    logic [7:0]  r_s1_q100;

    logic [23:0] r_s2_ydays;
    logic [9:0]  r_s2_mdays;

    logic [22:0] r_s3_dsh;

    logic [19:0] r_s4_cyear;
    logic [2:0]  r_s4_q0;

    logic [19:0] r_s5_cyear;
    logic [2:0]  r_s5_q0;
    logic [11:0] r_s5_a1;

    logic [19:0] r_s6_cyear;
    logic [2:0]  r_s6_q0;
    logic [11:0] r_s6_a1;
    logic [8:0]  r_s6_a2;

    logic [19:0] r_s7_cyear;
    logic [2:0]  r_s7_q0;
    logic [11:0] r_s7_a1;
    logic [22:0] r_s7_num;

    logic [19:0] r_s8_cyear;
    logic [2:0]  r_s8_q0;
    logic [11:0] r_s8_yc;

    logic [19:0] r_s9_cyear;
    logic [11:0] r_s9_yc;
    logic [13:0] r_s9_nq;
    logic [14:0] r_s9_year;

    logic [19:0] r_s10_cyear;
    logic [11:0] r_s10_yc;
    logic [9:0]  r_s10_fq;
    logic [14:0] r_s10_year;

    logic [8:0]  r_s11_yday;
    logic [14:0] r_s11_year;

    logic [4:0]  r_s12_day;
    logic [3:0]  r_s12_mon;
    logic [14:0] r_s12_year;

    // Next values and intermediate terms.
    logic [7:0]  n_s1_q100;
    logic [23:0] n_s2_ydays;
    logic [9:0]  n_s2_mdays;
    logic [22:0] n_s3_dsh;
    logic [19:0] n_s4_cyear;
    logic [2:0]  n_s4_q0;
    logic [11:0] n_s5_a1;
    logic [8:0]  n_s6_a2;
    logic [22:0] n_s7_num;
    logic [11:0] n_s8_yc;
    logic [13:0] n_s9_nq;
    logic [14:0] n_s9_year;
    logic [9:0]  n_s10_fq;
    logic [8:0]  n_s11_yday;
    logic [4:0]  n_s12_day;
    logic [3:0]  n_s12_mon;

    logic [27:0] w_p100;
    logic [13:0] w_r100_full;
    logic [6:0]  w_r100;
    logic        w_y4z;
    logic        w_c100;
    logic        w_c400;
    logic        w_leap;
    logic [23:0] w_dsh24;
    logic [40:0] w_p366;
    logic [2:0]  w_qq;
    logic [11:0] w_e;
    logic [21:0] w_n;
    logic [15:0] w_yraw;
    logic [15:0] w_ym1;
    logic [27:0] w_p11;
    logic [20:0] w_yday21;

    g2p_flow u_flow (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_flow      (flow)
    );

    assign s_axis_tready = flow.en[0];
    assign m_axis_tvalid = flow.vld[STAGES-1];
    assign m_axis_tdata  = {r_s12_year, r_s12_mon, r_s12_day};

    always_comb begin
        // Stage 1: year divided by 100 through a reciprocal multiply.
        w_p100    = 28'(r_s0_yr) * 28'(REC100);
        n_s1_q100 = w_p100[REC100_SH +: 8];

        // Stage 2: Gregorian day number, split into a year part and a month/day part.
        // The floor quotients of (year - 1) come from those of the year, less one
        // where the year is an exact multiple; year zero then gives minus one for each.
        w_r100_full = r_s1_yr - 14'(r_s1_q100) * 14'(100);
        w_r100      = w_r100_full[6:0];
        w_y4z       = (r_s1_yr[1:0] == 2'd0);
        w_c100      = (w_r100 == 7'd0);
        w_c400      = w_c100 && (r_s1_q100[1:0] == 2'd0);
        w_leap      = (w_y4z && !w_c100) || w_c400;
        n_s2_ydays  = 24'(r_s1_yr) * 24'(365) + 24'(r_s1_yr[13:2]) - 24'(r_s1_q100)
                    + 24'(r_s1_q100[7:2]) - 24'(w_y4z) + 24'(w_c100) - 24'(w_c400);
        n_s2_mdays  = 10'(GREG_MON_OFF[r_s1_mon]) + 10'(r_s1_day)
                    - ((r_s1_mon > 4'd2) ? (w_leap ? 10'd1 : 10'd2) : 10'd0);

        // Stage 3: days since the Persian epoch, biased by one cycle to stay positive.
        w_dsh24  = r_s2_ydays + {{14{r_s2_mdays[9]}}, r_s2_mdays} + 24'(DSH_BIAS);
        n_s3_dsh = w_dsh24[22:0];

        // Stage 4: cycle index and day within the cycle by compares against multiples.
        n_s4_q0 = 3'd0;
        for (int k = 1; k <= 6; k++) begin
            if (r_s3_dsh >= 23'(k * CYCLE_DAYS)) begin
                n_s4_q0 = 3'(k);
            end
        end
        n_s4_cyear = 20'(r_s3_dsh - 23'(n_s4_q0) * 23'(CYCLE_DAYS));

        // Stage 5: whole 366-day blocks in the cycle.
        w_p366  = 41'(r_s4_cyear) * 41'(REC366);
        n_s5_a1 = w_p366[REC366_SH +: 12];

        // Stage 6: remainder of the 366-day blocks.
        n_s6_a2 = 9'(r_s5_cyear - 20'(r_s5_a1) * 20'(366));

        // Stage 7: numerator of the year-in-cycle formula.
        n_s7_num = 23'(r_s6_a1) * 23'(2134) + 23'(r_s6_a2) * 23'(2816) + 23'(2815);

        // Stage 8: year within the cycle; the last day of a cycle ends year 2820.
        w_qq = 3'd0;
        for (int k = 1; k <= 6; k++) begin
            if (r_s7_num >= 23'(k * YEAR_SPAN)) begin
                w_qq = 3'(k);
            end
        end
        if (r_s7_cyear == 20'(CYCLE_DAYS - 1)) begin
            n_s8_yc = 12'(CYCLE_YEARS);
        end else begin
            n_s8_yc = r_s7_a1 + 12'(w_qq) + 12'd1;
        end

        // Stage 9: leap-day term numerator for the year start, and the year number
        // with year zero skipped.
        w_e     = r_s8_yc + 12'(EPOCH_YEAR);
        w_n     = 22'(w_e) * 22'(682) - 22'(110);
        n_s9_nq = w_n[21:8];
        w_yraw  = 16'(r_s8_yc) + 16'(r_s8_q0) * 16'(CYCLE_YEARS) - 16'(YEAR_BIAS);
        w_ym1   = w_yraw - 16'd1;
        if ($signed(w_yraw) <= 16'sd0) begin
            n_s9_year = w_ym1[14:0];
        end else begin
            n_s9_year = w_yraw[14:0];
        end

        // Stage 10: leap days before the year, numerator divided by 2816 = 256 * 11.
        w_p11    = 28'(r_s9_nq) * 28'(REC11);
        n_s10_fq = w_p11[REC11_SH +: 10];

        // Stage 11: day of the Persian year, 1 to 366.
        w_yday21   = 21'(r_s10_cyear) + 21'(YDAY_BIAS) - 21'(r_s10_yc) * 21'(365)
                   - 21'(r_s10_fq);
        n_s11_yday = w_yday21[8:0];

        // Stage 12: month by compares against month starts, then day of month.
        n_s12_mon = 4'd1;
        for (int k = 1; k < 12; k++) begin
            if (r_s11_yday >= pers_month_first(4'(k))) begin
                n_s12_mon = 4'(k + 1);
            end
        end
        n_s12_day = 5'(r_s11_yday - pers_month_first(n_s12_mon - 4'd1) + 9'd1);
    end

    always_ff @(posedge i_clk) begin
        if (flow.en[0]) begin
            r_s0_day <= s_axis_tdata[4:0];
            r_s0_mon <= s_axis_tdata[8:5];
            r_s0_yr  <= s_axis_tdata[22:9];
        end
        if (flow.en[1]) begin
            r_s1_day  <= r_s0_day;
            r_s1_mon  <= r_s0_mon;
            r_s1_yr   <= r_s0_yr;
            r_s1_q100 <= n_s1_q100;
        end
        if (flow.en[2]) begin
            r_s2_ydays <= n_s2_ydays;
            r_s2_mdays <= n_s2_mdays;
        end
        if (flow.en[3]) begin
            r_s3_dsh <= n_s3_dsh;
        end
        if (flow.en[4]) begin
            r_s4_cyear <= n_s4_cyear;
            r_s4_q0    <= n_s4_q0;
        end
        if (flow.en[5]) begin
            r_s5_cyear <= r_s4_cyear;
            r_s5_q0    <= r_s4_q0;
            r_s5_a1    <= n_s5_a1;
        end
        if (flow.en[6]) begin
            r_s6_cyear <= r_s5_cyear;
            r_s6_q0    <= r_s5_q0;
            r_s6_a1    <= r_s5_a1;
            r_s6_a2    <= n_s6_a2;
        end
        if (flow.en[7]) begin
            r_s7_cyear <= r_s6_cyear;
            r_s7_q0    <= r_s6_q0;
            r_s7_a1    <= r_s6_a1;
            r_s7_num   <= n_s7_num;
        end
        if (flow.en[8]) begin
            r_s8_cyear <= r_s7_cyear;
            r_s8_q0    <= r_s7_q0;
            r_s8_yc    <= n_s8_yc;
        end
        if (flow.en[9]) begin
            r_s9_cyear <= r_s8_cyear;
            r_s9_yc    <= r_s8_yc;
            r_s9_nq    <= n_s9_nq;
            r_s9_year  <= n_s9_year;
        end
        if (flow.en[10]) begin
            r_s10_cyear <= r_s9_cyear;
            r_s10_yc    <= r_s9_yc;
            r_s10_fq    <= n_s10_fq;
            r_s10_year  <= r_s9_year;
        end
        if (flow.en[11]) begin
            r_s11_yday <= n_s11_yday;
            r_s11_year <= r_s10_year;
        end
        if (flow.en[12]) begin
            r_s12_day  <= n_s12_day;
            r_s12_mon  <= n_s12_mon;
            r_s12_year <= r_s11_year;
        end
    end

endmodule
